FILE: hdl/rle_pkg.sv
// shared widths, register indexes and multiplier result type for the resonator block
package rle_pkg;

	localparam int TIME_BITS = 24;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 24;
	localparam int IDX_W = 3;

	localparam int IC_W = 24;
	localparam int B1_W = 18;
	localparam int B2_W = 17;
	localparam int LEN_W = 24;
	localparam int RCP_W = 17;
	localparam int Y_W = 32;

	// time and length compare width, and the signed note_len - t width
	localparam int CMP_W = (LEN_W > TIME_BITS) ? LEN_W : TIME_BITS;
	localparam int DIFF_W = CMP_W + 1;

	// serial multiplier: parallel multiplicand, multiplier shifted out one bit a cycle
	localparam int MC_W = (Y_W > DIFF_W) ? Y_W : DIFF_W;
	localparam int MP_W = 18;
	localparam int PROD_W = MC_W + 1 + MP_W;
	localparam int CNT_W = $clog2(MP_W);

	localparam logic [IDX_W-1:0] REG_INPUT_COEFF = 3'd0;
	localparam logic [IDX_W-1:0] REG_FEEDBACK_ONE = 3'd1;
	localparam logic [IDX_W-1:0] REG_FEEDBACK_TWO = 3'd2;
	localparam logic [IDX_W-1:0] REG_ATTACK_LEN = 3'd3;
	localparam logic [IDX_W-1:0] REG_ATTACK_RECIP = 3'd4;
	localparam logic [IDX_W-1:0] REG_RELEASE_START = 3'd5;
	localparam logic [IDX_W-1:0] REG_RELEASE_RECIP = 3'd6;
	localparam logic [IDX_W-1:0] REG_NOTE_LEN = 3'd7;

	typedef struct packed {
		logic done;
		logic signed [PROD_W-1:0] product;
	} mul_res_t;

endpackage

FILE: hdl/rle_mul.sv
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
module rle_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [rle_pkg::MC_W-1:0]    mcand,
	input  logic signed [rle_pkg::MP_W-1:0]    mplier,
	output rle_pkg::mul_res_t                  res
);

	logic                              busy_q;
	logic                              done_q;
	logic [rle_pkg::CNT_W-1:0]         cnt_q;
	logic signed [rle_pkg::MC_W-1:0]   mc_q;
	logic signed [rle_pkg::MC_W:0]     hi_q;
	logic [rle_pkg::MP_W-1:0]          lo_q;

	logic                              last;
	logic signed [rle_pkg::MC_W+1:0]   mc_ext;
	logic signed [rle_pkg::MC_W+1:0]   addend;
	logic signed [rle_pkg::MC_W+1:0]   sum;

	assign last = cnt_q == rle_pkg::CNT_W'(rle_pkg::MP_W - 1);
	assign mc_ext = {{2{mc_q[rle_pkg::MC_W-1]}}, mc_q};

	// the multiplier's sign bit carries negative weight
	always_comb begin
		if (!lo_q[0]) begin
			addend = '0;
		end else if (last) begin
			addend = -mc_ext;
		end else begin
			addend = mc_ext;
		end
	end

	assign sum = {hi_q[rle_pkg::MC_W], hi_q} + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// product bits shift into lo as multiplier bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[rle_pkg::MC_W+1:1];
			lo_q <= {sum[0], lo_q[rle_pkg::MP_W-1:1]};
		end
	end

	assign res.done = done_q;
	assign res.product = {hi_q, lo_q};

endmodule

FILE: hdl/resonator_with_linear_envelope.sv
// top level: two-pole resonator with linear attack/release envelope and output clip
// Each sample is filtered as y = a*x + b1*y1 - b2*y2, scaled by a linear attack or
// release gain, rounded and clipped to 16 bits; the unclipped enveloped value feeds back.
// The products go one after another through a single bit-serial multiplier that retires
// one multiplier bit per cycle: three products for the filter, one for the envelope gain
// while a ramp is active and one for the gained sample; while the gain is flat at unity
// the gain product is skipped. The block returns to idle when the result is registered
// and takes the next input transaction there. One transaction is in work at a time; a
// finished result waits in the output register, and the next input transaction is taken
// while it waits, but that sample cannot finish until the output register is free. A set
// first flag clears the sample counter and the filter history before that sample is
// processed. Registers are not held per sample, so write them only while the block is
// idle with nothing in flight.
module resonator_with_linear_envelope (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [rle_pkg::IDX_W-1:0]              cfg_index,
	input  logic [rle_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [rle_pkg::SAMPLE_W-1:0]    sample_in,
	input  logic                                   first,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rle_pkg::SAMPLE_W-1:0]    sample_out,
	output logic                                   playing
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILT_X = 3'd1;
	localparam logic [2:0] ST_FILT_Y1 = 3'd2;
	localparam logic [2:0] ST_FILT_Y2 = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_ENV = 3'd5;
	localparam logic [2:0] ST_OUT_MUL = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	localparam logic signed [rle_pkg::PROD_W-1:0] P_ONE = rle_pkg::PROD_W'(65536);
	localparam logic signed [rle_pkg::PROD_W-1:0] P_MONE = -P_ONE;
	localparam logic signed [rle_pkg::MP_W-1:0] ENV_ONE = rle_pkg::MP_W'(65536);
	localparam logic signed [rle_pkg::MP_W-1:0] ENV_MONE = -ENV_ONE;
	localparam logic signed [rle_pkg::SAMPLE_W-1:0] CLIP_POS = 16'sd32700;
	localparam logic signed [rle_pkg::SAMPLE_W-1:0] CLIP_NEG = -16'sd32700;

	// configuration registers
	logic signed [rle_pkg::IC_W-1:0]   ic_q;
	logic signed [rle_pkg::B1_W-1:0]   b1_q;
	logic [rle_pkg::B2_W-1:0]          b2_q;
	logic [rle_pkg::LEN_W-1:0]         att_len_q;
	logic [rle_pkg::RCP_W-1:0]         att_rcp_q;
	logic [rle_pkg::LEN_W-1:0]         rel_start_q;
	logic [rle_pkg::RCP_W-1:0]         rel_rcp_q;
	logic [rle_pkg::LEN_W-1:0]         note_len_q;

	logic [2:0]                        state_q;
	logic                              mul_start_q;
	logic                              out_valid_q;
	logic [rle_pkg::TIME_BITS-1:0]     t_q;
	logic signed [rle_pkg::Y_W-1:0]    y1_q;
	logic signed [rle_pkg::Y_W-1:0]    y2_q;

	logic signed [rle_pkg::SAMPLE_W-1:0] x_q;
	logic signed [rle_pkg::PROD_W-1:0]   acc_q;
	logic signed [rle_pkg::Y_W-1:0]      y_q;
	logic signed [rle_pkg::MP_W-1:0]     env_q;
	logic                                env_rel_q;
	logic signed [rle_pkg::Y_W-1:0]      ye_q;
	logic signed [rle_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                playing_q;

	logic                                in_accept;
	logic                                out_free;
	logic                                t_le_att;
	logic                                t_ge_rel;
	logic [rle_pkg::CMP_W:0]             t_inc;
	logic signed [rle_pkg::DIFF_W-1:0]   diff;
	logic signed [rle_pkg::MC_W-1:0]     mcand;
	logic signed [rle_pkg::MP_W-1:0]     mplier;
	rle_pkg::mul_res_t                   mul_res;
	logic signed [rle_pkg::PROD_W-1:0]   prod;

	// round half up by 16 fraction bits, then saturate to 32 bits
	function automatic logic signed [rle_pkg::Y_W-1:0] rnd_sat(
		input logic signed [rle_pkg::PROD_W-1:0] v
	);
		logic signed [rle_pkg::PROD_W:0]    w;
		logic signed [rle_pkg::PROD_W-16:0] s;
		w = {v[rle_pkg::PROD_W-1], v} + (rle_pkg::PROD_W+1)'(32768);
		s = w[rle_pkg::PROD_W:16];
		if (!s[rle_pkg::PROD_W-16] && (|s[rle_pkg::PROD_W-17:rle_pkg::Y_W-1])) begin
			return {1'b0, {(rle_pkg::Y_W-1){1'b1}}};
		end else if (s[rle_pkg::PROD_W-16] && !(&s[rle_pkg::PROD_W-17:rle_pkg::Y_W-1])) begin
			return {1'b1, {(rle_pkg::Y_W-1){1'b0}}};
		end else begin
			return s[rle_pkg::Y_W-1:0];
		end
	endfunction

	function automatic logic signed [rle_pkg::SAMPLE_W-1:0] clip16(
		input logic signed [rle_pkg::Y_W-1:0] v
	);
		if (!v[rle_pkg::Y_W-1] && (|v[rle_pkg::Y_W-2:rle_pkg::SAMPLE_W-1])) begin
			return CLIP_POS;
		end else if (v[rle_pkg::Y_W-1] && !(&v[rle_pkg::Y_W-2:rle_pkg::SAMPLE_W-1])) begin
			return CLIP_NEG;
		end else begin
			return v[rle_pkg::SAMPLE_W-1:0];
		end
	endfunction

	assign in_stall = state_q != ST_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign t_le_att = rle_pkg::CMP_W'(t_q) <= rle_pkg::CMP_W'(att_len_q);
	assign t_ge_rel = rle_pkg::CMP_W'(t_q) >= rle_pkg::CMP_W'(rel_start_q);
	assign t_inc = (rle_pkg::CMP_W+1)'(t_q) + 1'b1;
	assign diff = $signed(rle_pkg::DIFF_W'(note_len_q)) - $signed(rle_pkg::DIFF_W'(t_q));

	// operand select for the shared multiplier, latched on mul_start_q
	always_comb begin
		mcand = '0;
		mplier = '0;
		unique case (state_q)
			ST_FILT_X: begin
				mcand = rle_pkg::MC_W'(ic_q);
				mplier = rle_pkg::MP_W'(x_q);
			end
			ST_FILT_Y1: begin
				mcand = rle_pkg::MC_W'(y1_q);
				mplier = rle_pkg::MP_W'(b1_q);
			end
			ST_FILT_Y2: begin
				mcand = rle_pkg::MC_W'(y2_q);
				mplier = rle_pkg::MP_W'(b2_q);
			end
			ST_ENV: begin
				if (env_rel_q) begin
					mcand = rle_pkg::MC_W'(diff);
					mplier = rle_pkg::MP_W'(rel_rcp_q);
				end else begin
					mcand = rle_pkg::MC_W'(t_q);
					mplier = rle_pkg::MP_W'(att_rcp_q);
				end
			end
			ST_OUT_MUL: begin
				mcand = rle_pkg::MC_W'(y_q);
				mplier = env_q;
			end
			default: begin
				mcand = '0;
				mplier = '0;
			end
		endcase
	end

	rle_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.mcand  (mcand),
		.mplier (mplier),
		.res    (mul_res)
	);

	assign prod = mul_res.product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0;
			b1_q <= '0;
			b2_q <= rle_pkg::B2_W'(58982);
			att_len_q <= rle_pkg::LEN_W'(4410);
			att_rcp_q <= rle_pkg::RCP_W'(15);
			rel_start_q <= '0;
			rel_rcp_q <= rle_pkg::RCP_W'(15);
			note_len_q <= '0;
			state_q <= ST_IDLE;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			t_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else begin
			mul_start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					rle_pkg::REG_INPUT_COEFF:   ic_q <= cfg_data[rle_pkg::IC_W-1:0];
					rle_pkg::REG_FEEDBACK_ONE:  b1_q <= cfg_data[rle_pkg::B1_W-1:0];
					rle_pkg::REG_FEEDBACK_TWO:  b2_q <= cfg_data[rle_pkg::B2_W-1:0];
					rle_pkg::REG_ATTACK_LEN:    att_len_q <= cfg_data[rle_pkg::LEN_W-1:0];
					rle_pkg::REG_ATTACK_RECIP:  att_rcp_q <= cfg_data[rle_pkg::RCP_W-1:0];
					rle_pkg::REG_RELEASE_START: rel_start_q <= cfg_data[rle_pkg::LEN_W-1:0];
					rle_pkg::REG_RELEASE_RECIP: rel_rcp_q <= cfg_data[rle_pkg::RCP_W-1:0];
					rle_pkg::REG_NOTE_LEN:      note_len_q <= cfg_data[rle_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (first) begin
							t_q <= '0;
							y1_q <= '0;
							y2_q <= '0;
						end
						mul_start_q <= 1'b1;
						state_q <= ST_FILT_X;
					end
				end
				ST_FILT_X: begin
					if (mul_res.done) begin
						mul_start_q <= 1'b1;
						state_q <= ST_FILT_Y1;
					end
				end
				ST_FILT_Y1: begin
					if (mul_res.done) begin
						mul_start_q <= 1'b1;
						state_q <= ST_FILT_Y2;
					end
				end
				ST_FILT_Y2: begin
					if (mul_res.done) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					mul_start_q <= 1'b1;
					// flat envelope skips the gain product
					if (t_le_att || t_ge_rel) begin
						state_q <= ST_ENV;
					end else begin
						state_q <= ST_OUT_MUL;
					end
				end
				ST_ENV: begin
					if (mul_res.done) begin
						mul_start_q <= 1'b1;
						state_q <= ST_OUT_MUL;
					end
				end
				ST_OUT_MUL: begin
					if (mul_res.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						y2_q <= y1_q;
						y1_q <= ye_q;
						if (!(&t_q)) begin
							t_q <= t_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q <= sample_in;
		end
		unique case (state_q)
			ST_FILT_X: begin
				if (mul_res.done) begin
					acc_q <= prod;
				end
			end
			ST_FILT_Y1: begin
				if (mul_res.done) begin
					acc_q <= acc_q + prod;
				end
			end
			ST_FILT_Y2: begin
				if (mul_res.done) begin
					acc_q <= acc_q - prod;
				end
			end
			ST_ROUND: begin
				y_q <= rnd_sat(acc_q);
				env_rel_q <= !t_le_att;
				if (!t_le_att && !t_ge_rel) begin
					env_q <= ENV_ONE;
				end
			end
			ST_ENV: begin
				if (mul_res.done) begin
					if (prod > P_ONE) begin
						env_q <= ENV_ONE;
					end else if (env_rel_q && (prod < P_MONE)) begin
						env_q <= ENV_MONE;
					end else begin
						env_q <= prod[rle_pkg::MP_W-1:0];
					end
				end
			end
			ST_OUT_MUL: begin
				if (mul_res.done) begin
					ye_q <= rnd_sat(prod);
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					sample_out_q <= clip16(ye_q);
					playing_q <= t_inc < (rle_pkg::CMP_W+1)'(note_len_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign playing = playing_q;

	a_start_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> mul_start_q)
		else $error("multiplier not started after input transaction");

	a_done_in_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_res.done |-> (state_q == ST_FILT_X || state_q == ST_FILT_Y1 ||
			state_q == ST_FILT_Y2 || state_q == ST_ENV || state_q == ST_OUT_MUL))
		else $error("multiplier finished outside a product state");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_MUL) |-> (env_q <= ENV_ONE && env_q >= ENV_MONE))
		else $error("envelope gain out of range");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result shown without finishing a sample");

endmodule
